// ===== hw/rtl/wrfn_pkg.sv =====
// ============================================================================
// wrfn_pkg: shared types and constants
// Types, constants and the state enums used by the fit norm unit.
// ============================================================================
package wrfn_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_STEPS = 32 + FRAC_BITS + 1; // quotient bits kept (49)

    typedef enum logic [1:0] {
        MODE_PLAIN     = 2'd0,
        MODE_CHI       = 2'd1,
        MODE_SIM       = 2'd2,
        MODE_MEAN      = 2'd3
    } obj_mode_t;

    typedef struct packed {
        logic signed [31:0] sim_value;
        logic signed [31:0] exp_value;
        logic signed [31:0] scale_value;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic [31:0] fit_value;
        logic        saturated;
        logic        zero_divisor;
    } fit_t;

    // classified request between front and back
    typedef struct packed {
        logic [32:0] dmag;     // |(|sim| - exp)|
        logic [31:0] divisor;  // |sim| or |scale|
        logic        do_div;
        logic        zero_div;
        logic        last;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQR,
        BK_MUL,
        BK_ACC,
        BK_ROOT,
        BK_OUT
    } back_state_t;

endpackage

// ===== hw/rtl/wrfn_front.sv =====
// ============================================================================
// wrfn_front: input classification and job queue
// Forms residual magnitude and divisor; holds jobs in a two-entry queue.
// ============================================================================
module wrfn_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         obj_mode,
    input  wrfn_pkg::point_t   point,
    input  logic               push,
    output logic               full,
    output wrfn_pkg::job_t     job,
    output logic               job_valid,
    input  logic               job_take
);
    logic [32:0]        sim_abs;
    logic [32:0]        scale_abs;
    logic signed [34:0] diff;
    wrfn_pkg::job_t     job_in;
    wrfn_pkg::job_t     q_reg [2];
    logic               rd_ptr_reg, rd_ptr_next;
    logic               wr_ptr_reg, wr_ptr_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               do_push, do_pop;

    always_comb
    begin
        sim_abs   = point.sim_value[31] ? 33'(-{point.sim_value[31], point.sim_value})
                                        : {1'b0, point.sim_value};
        scale_abs = point.scale_value[31]
                  ? 33'(-{point.scale_value[31], point.scale_value})
                  : {1'b0, point.scale_value};
        diff      = $signed({2'b00, sim_abs}) - 35'(point.exp_value);
        job_in.dmag = diff[34] ? 33'(-diff) : diff[32:0];
        job_in.divisor = 32'(obj_mode == 2'(wrfn_pkg::MODE_SIM) ? sim_abs : scale_abs);
        // |x| of a 32-bit value can be 2^31, fits 32 bits unsigned
        job_in.do_div   = (obj_mode != 2'(wrfn_pkg::MODE_PLAIN));
        job_in.zero_div = job_in.do_div &&
            ((obj_mode == 2'(wrfn_pkg::MODE_SIM) ? sim_abs : scale_abs) == 33'd0);
        job_in.last     = point.last_point;
    end

    assign full      = (cnt_reg == 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = job_take && job_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= job_in;
        end
    end
endmodule

// ===== hw/rtl/wrfn_back.sv =====
// ============================================================================
// wrfn_back: divide, square, accumulate, root
// Shared restoring divider, one squaring, saturating sum, bit-pair sqrt.
// ============================================================================
module wrfn_back (
    input  logic               clk,
    input  logic               rst_n,
    input  wrfn_pkg::job_t     job,
    input  logic               job_valid,
    output logic               job_take,
    output wrfn_pkg::fit_t     result,
    output logic               empty,
    input  logic               pop
);
    localparam int NW = 33 + wrfn_pkg::FRAC_BITS; // dividend width

    wrfn_pkg::back_state_t state_reg, state_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [NW-1:0] num_reg, num_next;   // dividend shifts out, quotient shifts in
    logic [32:0]   rem_reg, rem_next;
    logic [31:0]   div_reg, div_next;
    logic [31:0]   r_reg, r_next;
    logic [63:0]   term_reg;
    logic [63:0]   acc_reg, acc_next;
    logic          sat_reg, sat_next;
    logic          zd_reg, zd_next;
    logic          last_reg, last_next;
    logic [63:0]   sx_reg, sx_next;     // sqrt remainder (radicand low part)
    logic [63:0]   sroot_reg, sroot_next;
    logic [63:0]   sbit_reg, sbit_next;
    wrfn_pkg::fit_t out_reg, out_next;
    logic          full_out_reg, full_out_next;

    logic [33:0]   trial;
    logic [63:0]   prod;
    logic [64:0]   sum65;
    logic [63:0]   cand;
    logic          out_free;

    assign out_free = !full_out_reg || pop;
    assign empty    = !full_out_reg;
    assign result   = out_reg;
    assign prod     = 64'(r_reg) * 64'(r_reg);
    assign trial    = {rem_reg, num_reg[NW-1]} - {2'b00, div_reg};
    assign sum65    = {1'b0, acc_reg} + {1'b0, term_reg};
    assign cand     = sroot_reg + sbit_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wrfn_pkg::BK_IDLE:
                if (job_valid)
                begin
                    if (job.zero_div)
                        state_next = job.last ? wrfn_pkg::BK_ROOT : wrfn_pkg::BK_IDLE;
                    else if (job.do_div)
                        state_next = wrfn_pkg::BK_DIV;
                    else
                        state_next = wrfn_pkg::BK_SQR;
                end
            wrfn_pkg::BK_DIV:
                if (cnt_reg == 6'(NW - 1))
                    state_next = wrfn_pkg::BK_SQR;
            wrfn_pkg::BK_SQR:
                state_next = wrfn_pkg::BK_MUL;
            wrfn_pkg::BK_MUL:
                state_next = wrfn_pkg::BK_ACC;
            wrfn_pkg::BK_ACC:
                state_next = last_reg ? wrfn_pkg::BK_ROOT : wrfn_pkg::BK_IDLE;
            wrfn_pkg::BK_ROOT:
                if (sbit_reg == 64'd0)
                    state_next = wrfn_pkg::BK_OUT;
            wrfn_pkg::BK_OUT:
                if (out_free)
                    state_next = wrfn_pkg::BK_IDLE;
            default:
                state_next = wrfn_pkg::BK_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        job_take      = 1'b0;
        cnt_next      = cnt_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        div_next      = div_reg;
        r_next        = r_reg;
        acc_next      = acc_reg;
        sat_next      = sat_reg;
        zd_next       = zd_reg;
        last_next     = last_reg;
        sx_next       = sx_reg;
        sroot_next    = sroot_reg;
        sbit_next     = sbit_reg;
        out_next      = out_reg;
        full_out_next = full_out_reg && !pop;
        unique case (state_reg)
            wrfn_pkg::BK_IDLE:
                if (job_valid)
                begin
                    job_take  = 1'b1;
                    last_next = job.last;
                    cnt_next  = 6'd0;
                    rem_next  = 33'd0;
                    num_next  = {job.dmag, wrfn_pkg::FRAC_BITS'(0)};
                    div_next  = job.divisor;
                    if (job.zero_div)
                        zd_next = 1'b1;
                    if (job.dmag[32])
                    begin
                        r_next   = 32'hFFFF_FFFF;
                        if (!job.do_div)
                            sat_next = 1'b1;
                    end
                    else
                        r_next = job.dmag[31:0];
                end
            wrfn_pkg::BK_DIV:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (!trial[33])
                begin
                    rem_next = trial[32:0];
                    num_next = {num_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[31:0], num_reg[NW-1]};
                    num_next = {num_reg[NW-2:0], 1'b0};
                end
            end
            wrfn_pkg::BK_SQR:
            begin
                // quotient saturation happens here for divided jobs
                if (cnt_reg != 6'd0 && num_reg[NW-1:32] != '0)
                begin
                    r_next   = 32'hFFFF_FFFF;
                    sat_next = 1'b1;
                end
                else if (cnt_reg != 6'd0)
                    r_next = num_reg[31:0];
                cnt_next = 6'd0;
            end
            wrfn_pkg::BK_ACC:
            begin
                // term was registered in the multiply step
                if (sum65[64])
                begin
                    acc_next = 64'hFFFF_FFFF_FFFF_FFFF;
                    sat_next = 1'b1;
                end
                else
                    acc_next = sum65[63:0];
            end
            wrfn_pkg::BK_ROOT:
                if (sbit_reg != 64'd0)
                begin
                    if (sx_reg >= cand)
                    begin
                        sx_next    = sx_reg - cand;
                        sroot_next = (sroot_reg >> 1) + sbit_reg;
                    end
                    else
                        sroot_next = sroot_reg >> 1;
                    sbit_next = sbit_reg >> 2;
                end
            wrfn_pkg::BK_OUT:
                if (out_free)
                begin
                    full_out_next = 1'b1;
                    out_next.zero_divisor = zd_reg;
                    if (acc_reg[63:64-wrfn_pkg::FRAC_BITS] != '0)
                    begin
                        out_next.fit_value = 32'hFFFF_FFFF;
                        out_next.saturated = 1'b1;
                    end
                    else
                    begin
                        out_next.fit_value = (sroot_reg[63:32] != '0) ? 32'hFFFF_FFFF
                                                                      : sroot_reg[31:0];
                        out_next.saturated = sat_reg;
                    end
                    acc_next = 64'd0;
                    sat_next = 1'b0;
                    zd_next  = 1'b0;
                end
            default:
                ;
        endcase
        if (state_reg == wrfn_pkg::BK_ACC || state_reg == wrfn_pkg::BK_IDLE)
        begin
            sx_next    = acc_next << wrfn_pkg::FRAC_BITS;
            sroot_next = 64'd0;
            sbit_next  = 64'd1 << 62;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= wrfn_pkg::BK_IDLE;
            acc_reg      <= 64'd0;
            sat_reg      <= 1'b0;
            zd_reg       <= 1'b0;
            full_out_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            sat_reg      <= sat_next;
            zd_reg       <= zd_next;
            full_out_reg <= full_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        r_reg     <= r_next;
        last_reg  <= last_next;
        sx_reg    <= sx_next;
        sroot_reg <= sroot_next;
        sbit_reg  <= sbit_next;
        out_reg   <= out_next;
        // settled r after the square step gives the term in the multiply step
        term_reg  <= prod >> wrfn_pkg::FRAC_BITS;
    end
endmodule

// ===== hw/rtl/weighted_residual_fit_norm_unit.sv =====
// ============================================================================
// weighted_residual_fit_norm_unit: root of summed squared residuals
// Top level: configuration register, front classifier, back datapath.
// ============================================================================
// Usage:
//   Input queue: drive point and push; a request is taken when push && !full.
//   Each point forms |(|sim| - exp)|, optionally divides it by |scale| or
//   |sim| (obj_mode), squares it and adds it to a saturating 64-bit sum.
//   Result queue: result is valid while empty is low; pop takes it. Only a
//   point with last_point set yields a result (sqrt of the sum in Q16.16,
//   saturated and zero_divisor flags); the sum and flags then clear.
//   Mode 0 takes, squares, multiplies and accumulates each point; divided
//   modes insert 49 quotient bits from the shared restoring divider, one
//   bit a cycle, after the take (a zero divisor is taken and skipped).
//   A last point then runs the two-bit-per-cycle square root and loads the result.
//   A two-entry queue sits between front and back, so push may continue
//   while the back is busy; full rises when both entries are waiting.
//   If the receiver does not pop, the result register holds and the back
//   waits at its output step; points behind it queue up.
//   Reset (rst_n low, asynchronous) clears mode to 0, sum, flags, queues.
//   cfg_we writes obj_mode from cfg_data; write only while idle.
// ============================================================================
module weighted_residual_fit_norm_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_data,
    input  wrfn_pkg::point_t point,
    input  logic             push,
    output logic             full,
    output wrfn_pkg::fit_t   result,
    output logic             empty,
    input  logic             pop
);
    logic [1:0]     mode_reg;
    wrfn_pkg::job_t job;
    logic           job_valid;
    logic           job_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 2'(wrfn_pkg::MODE_PLAIN);
        else if (cfg_we)
            mode_reg <= cfg_data;
    end

    wrfn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .obj_mode  (mode_reg),
        .point     (point),
        .push      (push),
        .full      (full),
        .job       (job),
        .job_valid (job_valid),
        .job_take  (job_take)
    );

    wrfn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_take  (job_take),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );
endmodule

// ===== hw/rtl/wrfn_checker.sv =====
// ============================================================================
// wrfn_checker: port-level checks
// Watches queue handshakes of the fit norm unit.
// ============================================================================
module wrfn_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           full,
    input logic           empty,
    input logic           pop,
    input wrfn_pkg::fit_t result
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while waiting");
    a_rst_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result present in reset");
    a_rst_full: assert property (@(posedge clk)
        !rst_n |=> !full)
        else $error("full in reset");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}))
        else $error("handshake output unknown");
endmodule

bind weighted_residual_fit_norm_unit wrfn_checker u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
